// File: rtl/tga_rle_pixel_decoder_macros.svh
// Assertion macros used by the checker file of the run-length pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TRPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trpd_pkg.sv
// Package: pixel modes, register indexes and per-mode byte counts of the pixel decoder.
`timescale 1ns / 1ps

package trpd_pkg;

  // Pixel modes (register pixel_mode)
  localparam logic [2:0] MODE_GRAY8   = 3'd0;
  localparam logic [2:0] MODE_GRAYA   = 3'd1;
  localparam logic [2:0] MODE_INDEXED = 3'd2;
  localparam logic [2:0] MODE_RGB555  = 3'd3;
  localparam logic [2:0] MODE_RGB24   = 3'd4;
  localparam logic [2:0] MODE_RGBA32  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_PIXEL_MODE      = 3'd0;
  localparam logic [2:0] CFG_RLE_ENABLE      = 3'd1;
  localparam logic [2:0] CFG_PIXEL_COUNT     = 3'd2;
  localparam logic [2:0] CFG_ID_LENGTH       = 3'd3;
  localparam logic [2:0] CFG_PALETTE_ENTRIES = 3'd4;

  localparam int CFG_DATA_W     = 25;
  localparam int PAL_ENTRY_W    = 24;
  localparam int MAX_PAL_ENTRIES = 256;
  localparam int REPEAT_MAX     = 128;

  // Stream bytes that make up one pixel in the given mode
  function automatic logic [2:0] bytes_of_mode(input logic [2:0] mode);
    logic [2:0] nb;
    unique case (mode)
      MODE_GRAYA:  nb = 3'd2;
      MODE_RGB555: nb = 3'd2;
      MODE_RGB24:  nb = 3'd3;
      MODE_RGBA32: nb = 3'd4;
      default:     nb = 3'd1;
    endcase
    return nb;
  endfunction

endpackage

// File: rtl/trpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module trpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data while not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tga_rle_pixel_decoder.sv
// Top level: run-length pixel decoder of a raster image byte stream.
//
// Usage: bytes of the image data that follow the fixed file header enter on
// in_valid/in_stall/in_stream_byte, one byte per item. The first id_length
// bytes are skipped, the next 3*min(palette_entries, 256) bytes load the
// palette RAM, then pixels are decoded (raw or run-length packets when
// rle_enable is set) until pixel_count pixels are covered. Each decoded
// pixel value leaves on the out_ channel with its channels reordered and a
// repeat count; out_image_done marks the item that completes the image.
// Later bytes are taken and dropped.
// Configuration: cfg_we/cfg_index/cfg_wdata, written while the block is idle.
// Timing: one byte accepted every cycle while in_stall is low; a pixel item
// passes the staged register (with the palette RAM read) and then the
// output register. Header, ID and palette bytes give no item.
// Stall: with out_stall high, the output register and one staged item hold,
// then in_stall rises; nothing is lost.
// Reset (rst_n low, synchronous): control registers take their defaults,
// decoding restarts at the ID field, both channels empty. The palette RAM
// is not cleared; entries are valid once loaded from the stream.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder #(
  parameter int PALETTE_DEPTH    = 256,
  parameter int PIXEL_COUNT_BITS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_wdata,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  // pixel items out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_chan_a,
  output logic [7:0]  out_chan_b,
  output logic [7:0]  out_chan_c,
  output logic [7:0]  out_chan_d,
  output logic [7:0]  out_repeat_count,
  output logic        out_image_done
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = (PIXEL_COUNT_BITS < trpd_pkg::CFG_DATA_W) ?
                         PIXEL_COUNT_BITS : trpd_pkg::CFG_DATA_W;

  typedef enum logic [1:0] {PH_ID, PH_PAL, PH_PIX, PH_DONE} phase_t;

  // configuration registers
  logic [2:0]       pixel_mode_r;
  logic             rle_enable_r;
  logic [CNT_W-1:0] pixel_count_r;
  logic [7:0]       id_length_r;
  logic [8:0]       palette_entries_r;

  // decode state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       id_cnt_r, id_cnt_nxt;
  logic [8:0]       pal_entry_r, pal_entry_nxt;
  logic [1:0]       pal_pos_r, pal_pos_nxt;
  logic [15:0]      pal_acc_r, pal_acc_nxt;
  logic [31:0]      pixel_bytes_r, pixel_bytes_nxt;
  logic [1:0]       byte_in_pixel_r, byte_in_pixel_nxt;
  logic [7:0]       packet_left_r, packet_left_nxt;
  logic             packet_is_repeat_r, packet_is_repeat_nxt;
  logic [CNT_W-1:0] pixels_done_r, pixels_done_nxt;

  // staged item waiting for the palette read
  logic             s1_valid_r;
  logic [2:0]       s1_mode_r;
  logic [31:0]      s1_bytes_r;
  logic [7:0]       s1_reps_r;
  logic             s1_done_r;
  logic             s1_idx_ok_r;

  // output register
  logic             out_valid_r;
  logic [7:0]       out_a_r, out_b_r, out_c_r, out_d_r, out_reps_r;
  logic             out_done_r;

  logic             in_acc, s1_move, produce;
  logic             pal_we;
  logic [23:0]      pal_wdata;
  logic [23:0]      pal_rdata;

  logic [7:0]       st_reps;
  logic             st_done;
  logic             st_idx_ok;
  logic [7:0]       a_nxt, b_nxt, c_nxt, d_nxt;

  // Handshake: stall only when the staged item and the output are both held
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  trpd_ram #(
    .WIDTH (trpd_pkg::PAL_ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_entry_r[AW-1:0]),
    .wdata (pal_wdata),
    .re    (in_acc),
    .raddr (in_stream_byte[AW-1:0]),
    .rdata (pal_rdata)
  );

  // Byte step: settle the phase, then skip, load palette or decode
  always_comb begin
    logic [8:0]       pal_n;
    phase_t           ph;
    logic [2:0]       nb;
    logic [31:0]      pb_base;
    logic [7:0]       reps_raw;
    logic [CNT_W-1:0] left;

    phase_nxt            = phase_r;
    id_cnt_nxt           = id_cnt_r;
    pal_entry_nxt        = pal_entry_r;
    pal_pos_nxt          = pal_pos_r;
    pal_acc_nxt          = pal_acc_r;
    pixel_bytes_nxt      = pixel_bytes_r;
    byte_in_pixel_nxt    = byte_in_pixel_r;
    packet_left_nxt      = packet_left_r;
    packet_is_repeat_nxt = packet_is_repeat_r;
    pixels_done_nxt      = pixels_done_r;
    produce              = 1'b0;
    pal_we               = 1'b0;
    pal_wdata            = 24'd0;
    st_reps              = 8'd1;
    st_done              = 1'b0;
    st_idx_ok            = ({1'b0, in_stream_byte} < 9'(PALETTE_DEPTH));

    pal_n = (palette_entries_r > 9'(trpd_pkg::MAX_PAL_ENTRIES)) ?
            9'(trpd_pkg::MAX_PAL_ENTRIES) : palette_entries_r;

    // pass phases that are already complete
    ph = phase_r;
    if (ph == PH_ID && id_cnt_r >= id_length_r) ph = PH_PAL;
    if (ph == PH_PAL && pal_entry_r >= pal_n) ph = PH_PIX;
    if (ph == PH_PIX && pixels_done_r >= pixel_count_r) ph = PH_DONE;

    nb       = trpd_pkg::bytes_of_mode(pixel_mode_r);
    pb_base  = (byte_in_pixel_r == 2'd0) ? 32'd0 : pixel_bytes_r;
    reps_raw = (rle_enable_r && packet_is_repeat_r) ? packet_left_r : 8'd1;
    left     = pixel_count_r - pixels_done_r;

    if (in_acc) begin
      phase_nxt = ph;
      unique case (ph)
        PH_ID: begin
          id_cnt_nxt = id_cnt_r + 8'd1;
        end
        PH_PAL: begin
          // write the entry with the bytes seen so far, upper bytes zero
          pal_we = (pal_entry_r < 9'(PALETTE_DEPTH));
          unique case (pal_pos_r)
            2'd0:    pal_wdata = {16'd0, in_stream_byte};
            2'd1:    pal_wdata = {8'd0, in_stream_byte, pal_acc_r[7:0]};
            default: pal_wdata = {in_stream_byte, pal_acc_r};
          endcase
          if (pal_pos_r == 2'd0) begin
            pal_acc_nxt = {8'd0, in_stream_byte};
          end else begin
            pal_acc_nxt = {in_stream_byte, pal_acc_r[7:0]};
          end
          if (pal_pos_r == 2'd2) begin
            pal_pos_nxt   = 2'd0;
            pal_entry_nxt = pal_entry_r + 9'd1;
          end else begin
            pal_pos_nxt = pal_pos_r + 2'd1;
          end
        end
        PH_PIX: begin
          if (rle_enable_r && packet_left_r == 8'd0) begin
            // packet header: count in low bits, repeat flag on top
            packet_left_nxt      = {1'b0, in_stream_byte[6:0]} + 8'd1;
            packet_is_repeat_nxt = in_stream_byte[7];
          end else begin
            pixel_bytes_nxt = pb_base | (32'(in_stream_byte) << {byte_in_pixel_r, 3'b000});
            if (({1'b0, byte_in_pixel_r} + 3'd1) < nb) begin
              byte_in_pixel_nxt = byte_in_pixel_r + 2'd1;
            end else begin
              // pixel complete: count it and clip to what is left
              byte_in_pixel_nxt = 2'd0;
              produce           = 1'b1;
              if (rle_enable_r && packet_is_repeat_r) begin
                packet_left_nxt = 8'd0;
              end else if (rle_enable_r) begin
                packet_left_nxt = packet_left_r - 8'd1;
              end
              st_reps = (CNT_W'(reps_raw) > left) ? left[7:0] : reps_raw;
              pixels_done_nxt = pixels_done_r + CNT_W'(st_reps);
              st_done = (pixels_done_nxt >= pixel_count_r);
              if (st_done) begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
        PH_DONE: begin
        end
      endcase
    end
  end

  // Reorder channels of the staged pixel
  always_comb begin
    logic [15:0] c555;
    c555  = s1_bytes_r[15:0];
    a_nxt = 8'd0;
    b_nxt = 8'd0;
    c_nxt = 8'd0;
    d_nxt = 8'd0;
    unique case (s1_mode_r)
      trpd_pkg::MODE_GRAYA: begin
        a_nxt = s1_bytes_r[7:0];
        b_nxt = s1_bytes_r[15:8];
      end
      trpd_pkg::MODE_INDEXED: begin
        if (s1_idx_ok_r) begin
          a_nxt = pal_rdata[23:16];
          b_nxt = pal_rdata[15:8];
          c_nxt = pal_rdata[7:0];
        end
      end
      trpd_pkg::MODE_RGB555: begin
        a_nxt = {c555[14:10], 3'b000};
        b_nxt = {c555[9:5], 3'b000};
        c_nxt = {c555[4:0], 3'b000};
      end
      trpd_pkg::MODE_RGB24: begin
        a_nxt = s1_bytes_r[23:16];
        b_nxt = s1_bytes_r[15:8];
        c_nxt = s1_bytes_r[7:0];
      end
      trpd_pkg::MODE_RGBA32: begin
        a_nxt = s1_bytes_r[23:16];
        b_nxt = s1_bytes_r[15:8];
        c_nxt = s1_bytes_r[7:0];
        d_nxt = s1_bytes_r[31:24];
      end
      default: begin
        a_nxt = s1_bytes_r[7:0];
      end
    endcase
  end

  // State, configuration, staged item and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r       <= trpd_pkg::MODE_GRAY8;
      rle_enable_r       <= 1'b0;
      pixel_count_r      <= CNT_W'(1);
      id_length_r        <= 8'd0;
      palette_entries_r  <= 9'd0;
      phase_r            <= PH_ID;
      id_cnt_r           <= 8'd0;
      pal_entry_r        <= 9'd0;
      pal_pos_r          <= 2'd0;
      pixel_bytes_r      <= 32'd0;
      byte_in_pixel_r    <= 2'd0;
      packet_left_r      <= 8'd0;
      packet_is_repeat_r <= 1'b0;
      pixels_done_r      <= '0;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          trpd_pkg::CFG_PIXEL_MODE:      pixel_mode_r      <= cfg_wdata[2:0];
          trpd_pkg::CFG_RLE_ENABLE:      rle_enable_r      <= cfg_wdata[0];
          trpd_pkg::CFG_PIXEL_COUNT:     pixel_count_r     <= cfg_wdata[CNT_W-1:0];
          trpd_pkg::CFG_ID_LENGTH:       id_length_r       <= cfg_wdata[7:0];
          trpd_pkg::CFG_PALETTE_ENTRIES: palette_entries_r <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end
      phase_r            <= phase_nxt;
      id_cnt_r           <= id_cnt_nxt;
      pal_entry_r        <= pal_entry_nxt;
      pal_pos_r          <= pal_pos_nxt;
      pixel_bytes_r      <= pixel_bytes_nxt;
      byte_in_pixel_r    <= byte_in_pixel_nxt;
      packet_left_r      <= packet_left_nxt;
      packet_is_repeat_r <= packet_is_repeat_nxt;
      pixels_done_r      <= pixels_done_nxt;

      if (produce) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pal_acc_r <= pal_acc_nxt;
    if (produce) begin
      s1_mode_r   <= pixel_mode_r;
      s1_bytes_r  <= pixel_bytes_nxt;
      s1_reps_r   <= st_reps;
      s1_done_r   <= st_done;
      s1_idx_ok_r <= st_idx_ok;
    end
    if (s1_move) begin
      out_a_r    <= a_nxt;
      out_b_r    <= b_nxt;
      out_c_r    <= c_nxt;
      out_d_r    <= d_nxt;
      out_reps_r <= s1_reps_r;
      out_done_r <= s1_done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chan_a       = out_a_r;
  assign out_chan_b       = out_b_r;
  assign out_chan_c       = out_c_r;
  assign out_chan_d       = out_d_r;
  assign out_repeat_count = out_reps_r;
  assign out_image_done   = out_done_r;

endmodule

// File: rtl/trpd_checker.sv
// Checker on the ports of the pixel decoder, bound to the top level.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"

module trpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_chan_a,
  input logic [7:0]  out_chan_b,
  input logic [7:0]  out_chan_c,
  input logic [7:0]  out_chan_d,
  input logic [7:0]  out_repeat_count,
  input logic        out_image_done
);

  // a stalled item holds its payload
  `TRPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_chan_a) && $stable(out_chan_b) && $stable(out_chan_c) && $stable(out_chan_d) && $stable(out_repeat_count) && $stable(out_image_done), "stalled output item changed")

  // repeat count stays within one packet
  `TRPD_ASSERT_NOW(a_reps_range, out_valid, out_repeat_count != 8'd0 && out_repeat_count <= 8'(trpd_pkg::REPEAT_MAX), "repeat count out of range")

  // the item that completes the image is the last one
  `TRPD_ASSERT_NEXT(a_done_last, out_valid && !out_stall && out_image_done, !out_valid, "item after image completion")

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

// File: test/tga_rle_pixel_decoder_tb.sv
// Testbench of the run-length pixel decoder: byte stream in, pixel items checked out.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;

  localparam logic [2:0]  MODE_SPARE6     = 3'd6;
  localparam logic [2:0]  MODE_SPARE7     = 3'd7;
  localparam logic        RUN_REPEAT      = 1'b1;
  localparam logic        RUN_LITERAL     = 1'b0;
  localparam logic [24:0] PIXEL_COUNT_MAX = 25'h1000000;
  localparam int          RANDOM_BYTES    = 240;
  localparam int          DRAIN_CYCLES    = 6;
  localparam int          LONG_HOLD       = 64;
  localparam int          WATCHDOG_LIMIT  = 1000;

  typedef enum logic [1:0] {ST_SKIP_ID, ST_LOAD_PAL, ST_PIXELS, ST_FINISHED} stream_state_t;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic [7:0] chan_d;
    logic [7:0] reps;
    logic       done;
  } pixel_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [24:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_chan_a;
  logic [7:0]  out_chan_b;
  logic [7:0]  out_chan_c;
  logic [7:0]  out_chan_d;
  logic [7:0]  out_repeat_count;
  logic        out_image_done;

  // decoder state as predicted from the accepted bytes
  logic [2:0]    m_mode;
  logic          m_rle;
  logic [24:0]   m_count;
  logic [7:0]    m_id_len;
  logic [8:0]    m_pal_n;
  stream_state_t st;
  logic [9:0]    st_cnt;
  logic [23:0]   palette [256];
  logic [31:0]   pix_word;
  logic [1:0]    pix_pos;
  logic [7:0]    pkt_left;
  logic          pkt_rep;
  logic [24:0]   pix_total;

  pixel_item_t pixel_q[$];

  int n_errors     = 0;
  int bytes_sent   = 0;
  int quiet_cycles = 0;
  bit in_idle_on   = 1'b1;
  bit out_idle_on  = 1'b1;
  bit long_hold_req = 1'b0;

  tga_rle_pixel_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chan_a       (out_chan_a),
    .out_chan_b       (out_chan_b),
    .out_chan_c       (out_chan_c),
    .out_chan_d       (out_chan_d),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done)
  );

  always #2 clk = ~clk;

  function automatic logic [2:0] bytes_per_pixel(input logic [2:0] mode);
    case (mode)
      trpd_pkg::MODE_GRAYA, trpd_pkg::MODE_RGB555: return 3'd2;
      trpd_pkg::MODE_RGB24:                        return 3'd3;
      trpd_pkg::MODE_RGBA32:                       return 3'd4;
      default:                                     return 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] rle_header(input logic kind, input int pixels);
    return {kind, 7'(pixels - 1)};
  endfunction

  // Step past phases whose length is already covered
  task automatic advance_phase();
    logic [9:0] pal_bytes;
    pal_bytes = (m_pal_n > 9'd256) ? 10'd768 : 10'(m_pal_n) * 10'd3;
    if (st == ST_SKIP_ID && st_cnt >= 10'(m_id_len)) begin
      st = ST_LOAD_PAL;
      st_cnt = '0;
    end
    if (st == ST_LOAD_PAL && st_cnt >= pal_bytes) begin
      st = ST_PIXELS;
      st_cnt = '0;
    end
    if (st == ST_PIXELS && pix_total >= m_count) st = ST_FINISHED;
  endtask

  // Predict the pixel item, if any, that one accepted byte completes
  task automatic predict_byte(input logic [7:0] b);
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] c555;
    logic [23:0] ent;
    logic [24:0] room;
    pixel_item_t px;
    advance_phase();
    if (st == ST_SKIP_ID) begin
      st_cnt = st_cnt + 10'd1;
    end else if (st == ST_LOAD_PAL) begin
      palette[st_cnt / 3][(st_cnt % 3) * 8 +: 8] = b;
      st_cnt = st_cnt + 10'd1;
    end else if (st == ST_PIXELS) begin
      if (m_rle && pkt_left == 8'd0) begin
        // open a packet
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        pkt_rep = b[7];
      end else begin
        if (pix_pos == 2'd0) pix_word = '0;
        pix_word[pix_pos * 8 +: 8] = b;
        if (pix_pos + 1 < bytes_per_pixel(m_mode)) begin
          pix_pos = pix_pos + 2'd1;
        end else begin
          pix_pos = 2'd0;
          {b3, b2, b1, b0} = pix_word;
          px = '0;
          case (m_mode)
            trpd_pkg::MODE_GRAYA: begin
              px.chan_a = b0;
              px.chan_b = b1;
            end
            trpd_pkg::MODE_INDEXED: begin
              ent = palette[b0];
              px.chan_a = ent[23:16];
              px.chan_b = ent[15:8];
              px.chan_c = ent[7:0];
            end
            trpd_pkg::MODE_RGB555: begin
              c555 = {b1, b0};
              px.chan_a = {c555[14:10], 3'b000};
              px.chan_b = {c555[9:5], 3'b000};
              px.chan_c = {c555[4:0], 3'b000};
            end
            trpd_pkg::MODE_RGB24: begin
              px.chan_a = b2;
              px.chan_b = b1;
              px.chan_c = b0;
            end
            trpd_pkg::MODE_RGBA32: begin
              px.chan_a = b2;
              px.chan_b = b1;
              px.chan_c = b0;
              px.chan_d = b3;
            end
            default: px.chan_a = b0;
          endcase
          if (m_rle && pkt_rep) begin
            px.reps = pkt_left;
            pkt_left = 8'd0;
          end else begin
            px.reps = 8'd1;
            if (m_rle) pkt_left = pkt_left - 8'd1;
          end
          // clip the run to the pixels left in the image
          room = m_count - pix_total;
          if (25'(px.reps) > room) px.reps = room[7:0];
          pix_total = pix_total + 25'(px.reps);
          if (pix_total >= m_count) begin
            px.done = 1'b1;
            st = ST_FINISHED;
          end
          pixel_q.push_back(px);
        end
      end
    end
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_byte(value);
    bytes_sent++;
  endtask

  task automatic send_pixel();
    repeat (bytes_per_pixel(m_mode)) send_byte(8'($urandom));
  endtask

  task automatic send_packet(input logic kind, input int pixels);
    send_byte(rle_header(kind, pixels));
    repeat ((kind == RUN_REPEAT) ? 1 : pixels) send_pixel();
  endtask

  // Drop valid and wait until every expected item has come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers while the block is idle
  task automatic set_config(input logic [2:0] mode, input logic rle, input logic [24:0] count,
                            input logic [7:0] id_len, input logic [8:0] pal_n);
    logic [24:0] reg_val [0:4];
    settle_idle();
    reg_val[trpd_pkg::CFG_PIXEL_MODE]      = 25'(mode);
    reg_val[trpd_pkg::CFG_RLE_ENABLE]      = 25'(rle);
    reg_val[trpd_pkg::CFG_PIXEL_COUNT]     = count;
    reg_val[trpd_pkg::CFG_ID_LENGTH]       = 25'(id_len);
    reg_val[trpd_pkg::CFG_PALETTE_ENTRIES] = 25'(pal_n);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= reg_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_mode = mode;
    m_rle = rle;
    m_count = count;
    m_id_len = id_len;
    m_pal_n = pal_n;
  endtask

  // Skip the ID field, shortening it midway to the bytes already taken
  task automatic test_id_skip();
    set_config(trpd_pkg::MODE_GRAY8, 1'b0, PIXEL_COUNT_MAX, 8'd255, 9'h1FF);
    repeat (30) send_byte(8'($urandom));
    set_config(trpd_pkg::MODE_GRAY8, 1'b0, PIXEL_COUNT_MAX, 8'd30, 9'h1FF);
  endtask

  // Load the full palette; an entry count above the palette size is clamped
  task automatic test_palette_load();
    repeat (768) send_byte(8'($urandom));
  endtask

  // One raw pixel per mode, bytes alternating between the extremes
  task automatic test_raw_modes();
    logic [2:0] modes [8];
    logic [7:0] fill;
    modes = '{trpd_pkg::MODE_GRAY8, trpd_pkg::MODE_GRAYA, trpd_pkg::MODE_INDEXED,
              trpd_pkg::MODE_RGB555, trpd_pkg::MODE_RGB24, trpd_pkg::MODE_RGBA32,
              MODE_SPARE6, MODE_SPARE7};
    for (int m = 0; m < 8; m++) begin
      set_config(modes[m], 1'b0, PIXEL_COUNT_MAX, 8'd0, 9'd256);
      fill = (m % 2 == 0) ? 8'hFF : 8'h00;
      repeat (bytes_per_pixel(modes[m])) begin
        send_byte(fill);
        fill = ~fill;
      end
    end
  endtask

  // Longest repeat run, shortest literal run, and a two-pixel literal run
  task automatic test_rle_packets();
    set_config(trpd_pkg::MODE_GRAYA, 1'b1, PIXEL_COUNT_MAX, 8'd255, 9'd0);
    send_byte(rle_header(RUN_REPEAT, 128));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(rle_header(RUN_LITERAL, 1));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(RUN_LITERAL, 2);
  endtask

  // Hold the output off for a long stretch while bytes keep coming
  task automatic test_output_backpressure();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    set_config(trpd_pkg::MODE_GRAY8, 1'b0, PIXEL_COUNT_MAX, 8'd0, 9'd0);
    long_hold_req = 1'b1;
    repeat (48) send_byte(8'($urandom));
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Random settings per phase; mostly well-formed pixels and packets, some stray bytes
  task automatic test_random_streams();
    int random_total;
    int phase_start;
    int budget;
    int pixels;
    random_total = 0;
    while (random_total < RANDOM_BYTES) begin
      in_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), PIXEL_COUNT_MAX,
                 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      phase_start = bytes_sent;
      budget = $urandom_range(40, 140);
      while (bytes_sent - phase_start < budget) begin
        if ($urandom_range(0, 11) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else if (m_rle) begin
          pixels = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
          send_packet(1'($urandom_range(0, 1)), pixels);
        end else begin
          send_pixel();
        end
      end
      // realign to a pixel and packet boundary before the next settings
      while (pix_pos != 2'd0 || (m_rle && pkt_left != 8'd0)) send_byte(8'($urandom));
      random_total += bytes_sent - phase_start;
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Clip a repeat run at the image end, then feed bytes that must be dropped
  task automatic test_image_end();
    set_config(trpd_pkg::MODE_GRAY8, 1'b1, pix_total + 25'd5, 8'd0, 9'd256);
    send_byte(rle_header(RUN_REPEAT, 16));
    send_byte(8'($urandom));
    repeat (10) send_byte(8'($urandom));
    set_config(trpd_pkg::MODE_RGBA32, 1'b0, 25'd0, 8'd255, 9'd0);
    repeat (4) send_byte(8'($urandom));
  endtask

  // Result side: random holds per item, plus one long hold on request
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      hold = out_idle_on ? $urandom_range(0, 18) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each accepted item with the oldest prediction
  always @(posedge clk) begin : check_pixels
    pixel_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel item: chan_a %0h repeat_count %0d", out_chan_a,
               out_repeat_count);
        n_errors++;
      end else begin
        want = pixel_q.pop_front();
        if (out_chan_a !== want.chan_a) begin
          $error("chan_a: expected %0h, got %0h", want.chan_a, out_chan_a);
          n_errors++;
        end
        if (out_chan_b !== want.chan_b) begin
          $error("chan_b: expected %0h, got %0h", want.chan_b, out_chan_b);
          n_errors++;
        end
        if (out_chan_c !== want.chan_c) begin
          $error("chan_c: expected %0h, got %0h", want.chan_c, out_chan_c);
          n_errors++;
        end
        if (out_chan_d !== want.chan_d) begin
          $error("chan_d: expected %0h, got %0h", want.chan_d, out_chan_d);
          n_errors++;
        end
        if (out_repeat_count !== want.reps) begin
          $error("repeat_count: expected %0d, got %0d", want.reps, out_repeat_count);
          n_errors++;
        end
        if (out_image_done !== want.done) begin
          $error("image_done: expected %0b, got %0b", want.done, out_image_done);
          n_errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_stream_byte = '0;
    m_mode = trpd_pkg::MODE_GRAY8;
    m_rle = 1'b0;
    m_count = 25'd1;
    m_id_len = '0;
    m_pal_n = '0;
    st = ST_SKIP_ID;
    st_cnt = '0;
    pix_word = '0;
    pix_pos = '0;
    pkt_left = '0;
    pkt_rep = 1'b0;
    pix_total = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_id_skip();
    test_palette_load();
    test_raw_modes();
    test_rle_packets();
    test_output_backpressure();
    test_random_streams();
    test_image_end();
    settle_idle();
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/trpd_pkg.sv
rtl/trpd_ram.sv
rtl/tga_rle_pixel_decoder.sv
rtl/trpd_checker.sv
test/tga_rle_pixel_decoder_tb.sv
